// ----- src/stfs_pkg.sv -----
// stfs_pkg: constants and types shared by the telemetry frame sender
// no dependencies
`default_nettype none

package stfs_pkg;

    typedef logic [7:0] t_byte;

    // configuration register indexes
    localparam logic [1:0] REG_GAP_MS         = 2'd0;
    localparam logic [1:0] REG_RSSI_DEVICE_ID = 2'd1;
    localparam logic [1:0] REG_ADC_DEVICE_ID  = 2'd2;
    localparam int unsigned CFG_IDX_W         = 2;

    // register reset values
    localparam t_byte GAP_MS_RST         = 8'd11;
    localparam t_byte RSSI_DEVICE_ID_RST = 8'h98;
    localparam t_byte ADC_DEVICE_ID_RST  = 8'he4;

    // frame bytes
    localparam t_byte START_BYTE      = 8'h7e;
    localparam t_byte ESC_BYTE        = 8'h7d;
    localparam t_byte ESC_MASK        = 8'h20;
    localparam t_byte FRAME_TYPE_BYTE = 8'h10;
    localparam t_byte CHECK_BASE      = 8'hff;

    localparam logic [15:0] ID_RSSI = 16'hf101;
    localparam logic [15:0] ID_ADC1 = 16'hf102;
    localparam logic [15:0] ID_ADC2 = 16'hf103;

    localparam int unsigned SLOT_COUNT_DEF = 3;

    // unstuffed frame: start, device, frame type, id lo/hi, 4 value bytes, check
    localparam int unsigned FRAME_RAW  = 10;
    localparam int unsigned FRAME_IDXW = 4;
    localparam int unsigned FIRST_STUFFED = 2;

    localparam logic [8:0] TICK_MAX = 9'd511;

endpackage

`default_nettype wire

// ----- src/stfs_tick_if.sv -----
// stfs_tick_if: valid/ready channel carrying one millisecond tick and its telemetry values
// no dependencies
`default_nettype none

interface stfs_tick_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rssi_value;
    logic [31:0] adc1_value;
    logic [31:0] adc2_value;

    modport source (output valid, output rssi_value, output adc1_value, output adc2_value,
                    input ready);
    modport sink   (input valid, input rssi_value, input adc1_value, input adc2_value,
                    output ready);
endinterface

`default_nettype wire

// ----- src/stfs_byte_if.sv -----
// stfs_byte_if: valid/ready channel carrying one serial byte of a telemetry frame
// no dependencies
`default_nettype none

interface stfs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_last;

    modport source (output valid, output out_byte, output frame_last, input ready);
    modport sink   (input valid, input out_byte, input frame_last, output ready);
endinterface

`default_nettype wire

// ----- src/sport_telemetry_frame_sender.sv -----
// sport_telemetry_frame_sender: counts ticks and sends round-robin telemetry frames bytewise
// depends on stfs_pkg, stfs_tick_if and stfs_byte_if
`default_nettype none

//  channel   | dir | payload                                  | transfer when
//  ----------+-----+------------------------------------------+----------------------------
//  i_tick    | in  | rssi_value, adc1_value, adc2_value       | i_tick.valid & i_tick.ready
//  o_frame   | out | out_byte, frame_last                     | o_frame.valid & o_frame.ready
//  i_cfg_*   | in  | i_cfg_idx, i_cfg_data                    | i_cfg_we
//
// a tick that sends no frame is always accepted, one per cycle, even while a frame drains
// a frame tick loads a ten-byte frame buffer when it is taken; the buffer then drains at one
// serial byte per cycle while o_frame is ready, 10 to 15 bytes per frame by how many are escaped
// a frame tick waits while the buffer still holds bytes, except on the cycle its last byte goes
// synchronous active-low reset clears the count, slot and buffer state and reloads the
// register defaults
// a stall on o_frame holds the current byte; the tick side keeps counting independently

module sport_telemetry_frame_sender
    import stfs_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    stfs_tick_if.sink                 i_tick,
    stfs_byte_if.source               o_frame,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]           i_cfg_data
);

    localparam logic [1:0] SLOT_LAST = 2'(SLOT_COUNT - 1);
    localparam logic [FRAME_IDXW-1:0] IDX_LAST  = FRAME_IDXW'(FRAME_RAW - 1);
    localparam logic [FRAME_IDXW-1:0] IDX_STUFF = FRAME_IDXW'(FIRST_STUFFED);

    // configuration registers
    t_byte r_gap_ms, r_rssi_dev, r_adc_dev;

    // tick and slot state
    logic [8:0] r_ticks, n_ticks;
    logic [1:0] r_slot, n_slot;

    // frame buffer and drain state
    t_byte                  r_frame [FRAME_RAW];
    logic                   r_busy;
    logic [FRAME_IDXW-1:0]  r_idx;
    logic                   r_esc;

    logic        fire, in_xfer, load, out_xfer, last_xfer;
    t_byte       cur_byte;
    logic        stuffable;
    t_byte       new_frame [FRAME_RAW];
    t_byte       dev;
    logic [15:0] data_id;
    logic [31:0] value;
    logic [10:0] sum_wide;
    logic [8:0]  sum_fold;
    t_byte       sum_ec;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ms   <= GAP_MS_RST;
            r_rssi_dev <= RSSI_DEVICE_ID_RST;
            r_adc_dev  <= ADC_DEVICE_ID_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAP_MS:         r_gap_ms   <= i_cfg_data;
                REG_RSSI_DEVICE_ID: r_rssi_dev <= i_cfg_data;
                REG_ADC_DEVICE_ID:  r_adc_dev  <= i_cfg_data;
                default: ;  // unknown index ignored
            endcase
        end
    end

    // tick counting: saturating count, frame when it passes the gap
    always_comb begin
        n_ticks = (r_ticks < TICK_MAX) ? r_ticks + 9'd1 : r_ticks;
        fire    = n_ticks > {1'b0, r_gap_ms};
        n_slot  = (r_slot >= SLOT_LAST) ? 2'd0 : r_slot + 2'd1;
    end

    // current byte with escape handling
    always_comb begin
        cur_byte  = r_frame[r_idx];
        stuffable = (r_idx >= IDX_STUFF) && (cur_byte == START_BYTE || cur_byte == ESC_BYTE);
    end

    assign o_frame.valid      = r_busy;
    assign o_frame.out_byte   = !stuffable ? cur_byte :
                                (r_esc ? (cur_byte ^ ESC_MASK) : ESC_BYTE);
    assign o_frame.frame_last = (r_idx == IDX_LAST) && (!stuffable || r_esc);

    assign out_xfer  = o_frame.valid && o_frame.ready;
    assign last_xfer = out_xfer && o_frame.frame_last;

    // frame ticks need the buffer free, or freeing this cycle
    assign i_tick.ready = !fire || !r_busy || last_xfer;
    assign in_xfer      = i_tick.valid && i_tick.ready;
    assign load         = in_xfer && fire;

    // frame assembly for the current slot
    always_comb begin
        case (r_slot)
            2'd0: begin
                dev     = r_rssi_dev;
                data_id = ID_RSSI;
                value   = {24'd0, i_tick.rssi_value};
            end
            2'd1: begin
                dev     = r_adc_dev;
                data_id = ID_ADC1;
                value   = i_tick.adc1_value;
            end
            default: begin
                dev     = r_adc_dev;
                data_id = ID_ADC2;
                value   = i_tick.adc2_value;
            end
        endcase

        new_frame[0] = START_BYTE;
        new_frame[1] = dev;
        new_frame[2] = FRAME_TYPE_BYTE;
        new_frame[3] = data_id[7:0];
        new_frame[4] = data_id[15:8];
        new_frame[5] = value[7:0];
        new_frame[6] = value[15:8];
        new_frame[7] = value[23:16];
        new_frame[8] = value[31:24];

        // end-around-carry sum: wide add then two folds; the frame type byte keeps it nonzero
        sum_wide = {3'd0, new_frame[2]} + {3'd0, new_frame[3]} + {3'd0, new_frame[4]}
                 + {3'd0, new_frame[5]} + {3'd0, new_frame[6]} + {3'd0, new_frame[7]}
                 + {3'd0, new_frame[8]};
        sum_fold = {1'b0, sum_wide[7:0]} + {6'd0, sum_wide[10:8]};
        sum_ec   = sum_fold[7:0] + {7'd0, sum_fold[8]};
        new_frame[9] = CHECK_BASE - sum_ec;
    end

    // tick and slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= '0;
            r_slot  <= '0;
        end else if (in_xfer) begin
            r_ticks <= fire ? 9'd0 : n_ticks;
            if (fire) begin
                r_slot <= n_slot;
            end
        end
    end

    // frame buffer drain control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_esc  <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_esc  <= 1'b0;
        end else if (out_xfer) begin
            if (stuffable && !r_esc) begin
                r_esc <= 1'b1;  // escape byte sent, flipped byte follows
            end else begin
                r_esc <= 1'b0;
                if (o_frame.frame_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + FRAME_IDXW'(1);
                end
            end
        end
    end

    // frame buffer payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_frame <= new_frame;
        end
    end

    // buffer index never runs past the check byte
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= IDX_LAST)
        else $error("frame index beyond check byte");

    // the last byte leaving without a new load empties the buffer
    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (last_xfer && !load) |=> !r_busy)
        else $error("buffer still busy after last byte");

    // a frame load restarts the tick count and fills the buffer from its start
    a_load_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_ticks == 9'd0) && r_busy && (r_idx == '0) && !r_esc)
        else $error("frame load did not restart count and buffer");

    // escape phase only on a byte that needs escaping
    a_esc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> (r_busy && stuffable))
        else $error("escape phase on a plain byte");

    // slot stays within the configured round robin
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_LAST)
        else $error("slot index out of range");

endmodule

`default_nettype wire
